@@ design/osbf_pkg.sv @@
// ----------------------------------------------------------------------------
// osbf_pkg
// Shared constants, payload types and controller states for the
// overlap-save block FIR core.
// ----------------------------------------------------------------------------
package osbf_pkg;

	// Samples per frame; also the number of taps.
	localparam int FRAME_LEN = 32;

	// Offset within one frame bank.
	localparam int OFS_W = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;

	// Q2.30 products summed over FRAME_LEN terms plus rounding bias.
	localparam int ACC_W = 33 + OFS_W;

	// Quotient width after dropping the 15 fraction bits.
	localparam int Q_W = ACC_W - 15;

	// Item kind codes.
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TAP    = 1'b1;

	typedef struct packed {
		logic              kind;
		logic signed [15:0] sample;
		logic [4:0]        tap_index;
		logic signed [15:0] tap_value;
	} in_t;

	typedef struct packed {
		logic signed [15:0] out_sample;
		logic              last_of_frame;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

endpackage

@@ design/overlap_save_block_fir_core.sv @@
// Results: once a frame's last sample is taken, its outputs are computed in order,
// and each is registered when its last product has been accumulated.
// Input: a tap write or a sample that does not close a frame is taken while idle;
// a closing sample holds the input until the whole frame is computed (one shared
// MAC, one history read per cycle while the output is not stalled).
// Reset (arst_n low, asynchronous): taps and previous frame read as zero, frame empty.
// ----------------------------------------------------------------------------
// overlap_save_block_fir_core
// Frame-based FIR in overlap-save form. Samples are gathered into one bank
// of the history memory; when a frame closes, every output is computed as
// sum_k tap[k] * x[n-k] over the previous and current banks on a single
// pipelined multiply-accumulate, then rounded and saturated to Q1.15.
// ----------------------------------------------------------------------------
module overlap_save_block_fir_core
	import osbf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,

	input  logic item_valid,
	output logic item_stall,
	input  in_t  item,

	output logic res_valid,
	input  logic res_stall,
	output out_t res
);

	localparam logic [OFS_W-1:0]       LAST_IDX = OFS_W'(FRAME_LEN - 1);
	localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'(16384);
	localparam logic signed [Q_W-1:0]  Q_MAX    = Q_W'(32767);
	localparam logic signed [Q_W-1:0]  Q_MIN    = -Q_W'(32768);

	// ------------------------------------------------------------------
	// Control state
	// ------------------------------------------------------------------
	state_t            state_q, state_nxt;
	logic [OFS_W-1:0]  fill_q;        // samples gathered in the current frame
	logic              bank_q;        // history bank holding the current frame
	logic              prev_vld_q;    // previous bank holds a real frame
	logic [FRAME_LEN-1:0] tap_vld_q;  // tap written since reset
	logic [OFS_W-1:0]  m_q, k_q;      // output index, tap index

	// Pipeline: s1 = memory read data, s2 = product, then accumulator.
	logic              v_s1, last_k_s1, last_m_s1, zero_s1, tvld_s1;
	logic signed [15:0] tap_s1, hist_s1;
	logic              v_s2, last_k_s2, last_m_s2;
	logic signed [31:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q, acc_nxt;

	logic              res_vld_q;
	out_t              res_q;

	// Whole datapath advances unless a finished result is still held.
	logic adv;
	assign adv = !res_vld_q || !res_stall;

	logic in_acc, smp_acc, tap_acc, frame_close, issue, frame_done;
	assign in_acc      = item_valid && !item_stall;
	assign smp_acc     = in_acc && (item.kind == KIND_SAMPLE);
	assign tap_acc     = in_acc && (item.kind == KIND_TAP) && (int'(item.tap_index) < FRAME_LEN);
	assign frame_close = smp_acc && (fill_q == LAST_IDX);
	assign issue       = adv && (state_q == ST_RUN);
	assign frame_done  = adv && v_s2 && last_k_s2 && last_m_s2;

	// ------------------------------------------------------------------
	// Read address: logical position FRAME_LEN + m - k
	// ------------------------------------------------------------------
	logic [OFS_W:0]   diff;
	logic [OFS_W-1:0] rd_ofs;
	logic             rd_bank, rd_zero;

	always_comb begin
		diff = {1'b0, m_q} - {1'b0, k_q};
		if (diff[OFS_W]) begin
			// reaches back into the previous frame
			rd_ofs  = OFS_W'(diff + (OFS_W + 1)'(FRAME_LEN));
			rd_bank = ~bank_q;
			rd_zero = !prev_vld_q;
		end else begin
			rd_ofs  = diff[OFS_W-1:0];
			rd_bank = bank_q;
			rd_zero = 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Memories
	// ------------------------------------------------------------------
	logic signed [15:0] hist_mem [2**(OFS_W+1)];
	logic signed [15:0] tap_mem  [FRAME_LEN];

	always_ff @(posedge clk) begin
		if (smp_acc) begin
			hist_mem[{bank_q, fill_q}] <= item.sample;
		end
		if (issue) begin
			hist_s1 <= hist_mem[{rd_bank, rd_ofs}];
		end
	end

	always_ff @(posedge clk) begin
		if (tap_acc) begin
			tap_mem[OFS_W'(item.tap_index)] <= item.tap_value;
		end
		if (issue) begin
			tap_s1 <= tap_mem[k_q];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (frame_close) state_nxt = ST_RUN;
			end
			ST_RUN: begin
				if (issue && (k_q == LAST_IDX) && (m_q == LAST_IDX)) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (frame_done) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE: item_stall = 1'b0;
			default: item_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			bank_q     <= 1'b0;
			prev_vld_q <= 1'b0;
			tap_vld_q  <= '0;
			m_q        <= '0;
			k_q        <= '0;
		end else begin
			state_q <= state_nxt;
			if (tap_acc) begin
				tap_vld_q[OFS_W'(item.tap_index)] <= 1'b1;
			end
			if (smp_acc) begin
				fill_q <= frame_close ? '0 : fill_q + 1'b1;
			end
			if (issue) begin
				if (k_q == LAST_IDX) begin
					k_q <= '0;
					m_q <= (m_q == LAST_IDX) ? '0 : m_q + 1'b1;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			// current frame becomes the previous one
			if (frame_done) begin
				bank_q     <= ~bank_q;
				prev_vld_q <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// MAC pipeline control
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			last_k_s1 <= 1'b0;
			last_m_s1 <= 1'b0;
			last_k_s2 <= 1'b0;
			last_m_s2 <= 1'b0;
			zero_s1   <= 1'b0;
			tvld_s1   <= 1'b0;
			acc_q     <= BIAS;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			v_s1      <= issue;
			last_k_s1 <= (k_q == LAST_IDX);
			last_m_s1 <= (m_q == LAST_IDX);
			zero_s1   <= rd_zero;
			tvld_s1   <= tap_vld_q[k_q];
			v_s2      <= v_s1;
			last_k_s2 <= last_k_s1;
			last_m_s2 <= last_m_s1;
			if (v_s2) begin
				// bias preloaded so the final shift rounds half up
				acc_q <= last_k_s2 ? BIAS : acc_nxt;
			end
			res_vld_q <= v_s2 && last_k_s2;
		end
	end

	// Unwritten taps and the empty previous frame read as zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= (zero_s1 || !tvld_s1) ? 32'sd0 : tap_s1 * hist_s1;
		end
	end

	assign acc_nxt = acc_q + ACC_W'(prod_s2);

	// Round (bias already in) and saturate to Q1.15.
	logic signed [Q_W-1:0] quo;
	logic signed [15:0]    sat;
	always_comb begin
		quo = acc_nxt[ACC_W-1:15];
		if (quo > Q_MAX) begin
			sat = 16'sh7FFF;
		end else if (quo < Q_MIN) begin
			sat = -16'sh8000;
		end else begin
			sat = quo[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && last_k_s2) begin
			res_q.out_sample    <= sat;
			res_q.last_of_frame <= last_m_s2;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!v_s1 && !v_s2))
		else $error("MAC pipeline busy while idle");

	a_close_starts: assert property (@(posedge clk) disable iff (!arst_n)
		frame_close |=> (state_q == ST_RUN))
		else $error("closing sample did not start a frame");

	a_fill_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (fill_q == '0))
		else $error("fill count nonzero during frame compute");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> (res_valid && res.last_of_frame && (state_q == ST_IDLE)))
		else $error("frame end not marked on output");

endmodule
